// ===== design/pyus_pkg.sv =====
`timescale 1ns / 1ps

package pyus_pkg;

    localparam int MAX_TABLES = 4096;
    localparam int COUNT_BITS = 20;

    localparam int IDX_W   = $clog2(MAX_TABLES);
    localparam int TAB_W   = $clog2(MAX_TABLES + 1);
    localparam int DRAW_W  = 20;
    localparam int ALPHA_W = 16;
    localparam int THETA_W = 32;
    localparam int U_W     = 32;
    localparam int FRAC_W  = 16;

    // fixed widths of the result fields
    localparam int OUT_IDX_W = 12;
    localparam int OUT_TAB_W = 13;
    localparam int OUT_W     = OUT_IDX_W + 1 + OUT_TAB_W + 1;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    // s = theta + n in q16.16, y = floor(u * s / 2^32)
    localparam int S_W    = DRAW_W + FRAC_W + 1;
    localparam int SHI_W  = S_W - U_W;
    localparam int PLO_W  = 2 * U_W;
    localparam int PHI_W  = U_W + SHI_W;
    localparam int Y_W    = S_W;
    localparam int DA_W   = TAB_W + ALPHA_W;
    localparam int T_W    = ((THETA_W > DA_W) ? THETA_W : DA_W) + 1;
    localparam int CMP_W  = (Y_W > T_W) ? Y_W : T_W;
    localparam int TERM_W = COUNT_BITS + FRAC_W;
    localparam int SUM_W  = TERM_W + IDX_W;

    localparam logic [DRAW_W-1:0]     DRAW_MAX  = {DRAW_W{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [ALPHA_W-1:0] DISCOUNT_RESET      = ALPHA_W'(26214);
    localparam logic [THETA_W-1:0] CONCENTRATION_RESET = THETA_W'(3276800);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = THETA_W;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CONCENTRATION = 1'b1;

    typedef struct packed {
        logic               start;
        logic               open;
        logic [TAB_W-1:0]   d;
        logic [Y_W-1:0]     x;
        logic [ALPHA_W-1:0] alpha;
    } walk_cmd_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] chosen;
    } walk_rsp_t;

endpackage

// ===== design/pyus_walk.sv =====
`timescale 1ns / 1ps

module pyus_walk (
    input  logic                clk,
    input  logic                rst_n,
    input  pyus_pkg::walk_cmd_t cmd,
    output pyus_pkg::walk_rsp_t rsp
);
    import pyus_pkg::*;

    logic [COUNT_BITS-1:0] occ_mem [MAX_TABLES];
    logic [COUNT_BITS-1:0] rd_q_reg;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    logic busy_reg, busy_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic rd_more_reg, rd_more_next;
    logic d1_valid_reg, d1_valid_next;
    logic [IDX_W-1:0] d1_idx_reg, d1_idx_next;
    logic t_valid_reg, t_valid_next;
    logic [TERM_W-1:0] term_reg, term_next;
    logic [COUNT_BITS-1:0] t_cnt_reg, t_cnt_next;
    logic [IDX_W-1:0] t_idx_reg, t_idx_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [Y_W-1:0] x_reg, x_next;
    logic [ALPHA_W-1:0] alpha_reg, alpha_next;

    logic [TERM_W-1:0] full_term;
    logic [SUM_W-1:0]  sum_new;
    logic              finish;
    logic [IDX_W-1:0]  first_idx;

    assign full_term = {rd_q_reg, {FRAC_W{1'b0}}};
    assign sum_new   = sum_reg + SUM_W'(term_reg);
    assign finish    = busy_reg && t_valid_reg
                       && ((sum_new > SUM_W'(x_reg)) || (t_idx_reg == '0));
    assign first_idx = IDX_W'(cmd.d - TAB_W'(1));

    always_comb
    begin
        busy_next     = busy_reg;
        rd_idx_next   = rd_idx_reg;
        rd_more_next  = rd_more_reg;
        d1_valid_next = d1_valid_reg;
        d1_idx_next   = d1_idx_reg;
        t_valid_next  = t_valid_reg;
        term_next     = term_reg;
        t_cnt_next    = t_cnt_reg;
        t_idx_next    = t_idx_reg;
        sum_next      = sum_reg;
        x_next        = x_reg;
        alpha_next    = alpha_reg;
        rd_en         = 1'b0;
        rd_addr       = rd_idx_reg;
        wr_en         = 1'b0;
        wr_addr       = t_idx_reg;
        wr_data       = (t_cnt_reg == COUNT_MAX) ? t_cnt_reg : t_cnt_reg + COUNT_BITS'(1);
        rsp.done      = finish;
        rsp.chosen    = t_idx_reg;

        if (!busy_reg)
        begin
            if (cmd.open)
            begin
                // a table beyond the count was never read, so its count starts at one
                wr_en   = 1'b1;
                wr_addr = IDX_W'(cmd.d);
                wr_data = COUNT_BITS'(1);
            end
            else if (cmd.start)
            begin
                busy_next     = 1'b1;
                x_next        = cmd.x;
                alpha_next    = cmd.alpha;
                sum_next      = '0;
                t_valid_next  = 1'b0;
                rd_en         = 1'b1;
                rd_addr       = first_idx;
                d1_valid_next = 1'b1;
                d1_idx_next   = first_idx;
                rd_more_next  = (first_idx != '0);
                rd_idx_next   = first_idx - IDX_W'(1);
            end
        end
        else if (finish)
        begin
            // bump the chosen table with the count already read
            wr_en         = 1'b1;
            busy_next     = 1'b0;
            t_valid_next  = 1'b0;
            d1_valid_next = 1'b0;
            rd_more_next  = 1'b0;
        end
        else
        begin
            if (t_valid_reg)
                sum_next = sum_new;
            t_valid_next = d1_valid_reg;
            term_next    = (full_term >= TERM_W'(alpha_reg))
                           ? full_term - TERM_W'(alpha_reg) : '0;
            t_cnt_next   = rd_q_reg;
            t_idx_next   = d1_idx_reg;
            d1_valid_next = rd_more_reg;
            d1_idx_next   = rd_idx_reg;
            if (rd_more_reg)
            begin
                rd_en   = 1'b1;
                rd_addr = rd_idx_reg;
                if (rd_idx_reg == '0)
                    rd_more_next = 1'b0;
                else
                    rd_idx_next = rd_idx_reg - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            occ_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_q_reg <= occ_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            rd_more_reg  <= 1'b0;
            d1_valid_reg <= 1'b0;
            t_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            rd_more_reg  <= rd_more_next;
            d1_valid_reg <= d1_valid_next;
            t_valid_reg  <= t_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        d1_idx_reg <= d1_idx_next;
        term_reg   <= term_next;
        t_cnt_reg  <= t_cnt_next;
        t_idx_reg  <= t_idx_next;
        sum_reg    <= sum_next;
        x_reg      <= x_next;
        alpha_reg  <= alpha_next;
    end

endmodule

// ===== design/pitman_yor_urn_sampler_top.sv =====
`timescale 1ns / 1ps

// channel   | direction | handshake                     | payload
// ----------+-----------+-------------------------------+--------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tdata: uniform_sample
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: table_index, opened_new,
//           |           |                               |        tables_in_use, store_full
// cfg       | in        | cfg_wr_en                     | cfg_index, cfg_data
//
// a draw that opens a table (or finds the store full) goes through S_MUL, S_SUM, S_DEC
// and S_EMIT to the output register; a draw that picks an existing table walks the
// stored counts from the top one per cycle through the single read port.
// reset clears counters and control and loads the config defaults; no clearing pass, counts
// at or above the table count are never read and a new table writes its count directly.
// a new item is taken while the previous result still waits in the output register.

module pitman_yor_urn_sampler_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [pyus_pkg::U_W-1:0]              s_axis_tdata,  // [31:0] uniform_sample
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [11:0] table_index, [12] opened_new, [25:13] tables_in_use, [26] store_full
    output logic [pyus_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input  logic                                  cfg_wr_en,
    input  logic [pyus_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pyus_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import pyus_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_SUM  = 6'b000100,
        S_DEC  = 6'b001000,
        S_WALK = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    logic [THETA_W-1:0] theta_reg, theta_next;
    logic [TAB_W-1:0]   d_reg, d_next;
    logic [DRAW_W-1:0]  draw_reg, draw_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [U_W-1:0]   u_reg, u_next;
    logic [S_W-1:0]   s_reg, s_next;
    logic [PLO_W-1:0] p_lo_reg, p_lo_next;
    logic [PHI_W-1:0] p_hi_reg, p_hi_next;
    logic [T_W-1:0]   t_reg, t_next;
    logic [Y_W-1:0]   y_reg, y_next;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    logic             res_open_reg, res_open_next;
    logic             res_full_reg, res_full_next;

    walk_cmd_t walk_cmd;
    walk_rsp_t walk_rsp;

    logic             in_fire;
    logic             want_open;
    logic [DRAW_W-1:0] draw_inc;
    logic [OUT_W-1:0]  result;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign want_open = (d_reg == '0) || (CMP_W'(y_reg) < CMP_W'(t_reg));
    assign draw_inc  = (draw_reg == DRAW_MAX) ? draw_reg : draw_reg + DRAW_W'(1);
    assign result    = {res_full_reg, OUT_TAB_W'(d_reg), res_open_reg, OUT_IDX_W'(res_idx_reg)};

    pyus_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (walk_cmd),
        .rsp   (walk_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        alpha_next     = alpha_reg;
        theta_next     = theta_reg;
        d_next         = d_reg;
        draw_next      = draw_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        u_next         = u_reg;
        s_next         = s_reg;
        p_lo_next      = p_lo_reg;
        p_hi_next      = p_hi_reg;
        t_next         = t_reg;
        y_next         = y_reg;
        res_idx_next   = res_idx_reg;
        res_open_next  = res_open_reg;
        res_full_next  = res_full_reg;
        walk_cmd.start = 1'b0;
        walk_cmd.open  = 1'b0;
        walk_cmd.d     = d_reg;
        walk_cmd.x     = y_reg - Y_W'(t_reg);
        walk_cmd.alpha = alpha_reg;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_DISCOUNT:      alpha_next = cfg_data[ALPHA_W-1:0];
                REG_CONCENTRATION: theta_next = cfg_data[THETA_W-1:0];
                default:           ;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    u_next     = s_axis_tdata;
                    s_next     = S_W'(theta_reg) + S_W'({draw_reg, {FRAC_W{1'b0}}});
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                p_lo_next  = PLO_W'(u_reg) * PLO_W'(s_reg[U_W-1:0]);
                p_hi_next  = PHI_W'(u_reg) * PHI_W'(s_reg[S_W-1:U_W]);
                t_next     = T_W'(theta_reg) + T_W'(DA_W'(d_reg) * DA_W'(alpha_reg));
                state_next = S_SUM;
            end
            S_SUM:
            begin
                y_next     = Y_W'(p_hi_reg) + Y_W'(p_lo_reg[PLO_W-1:U_W]);
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (want_open)
                begin
                    if (d_reg == TAB_W'(MAX_TABLES))
                    begin
                        res_idx_next  = '0;
                        res_open_next = 1'b0;
                        res_full_next = 1'b1;
                    end
                    else
                    begin
                        walk_cmd.open = 1'b1;
                        res_idx_next  = IDX_W'(d_reg);
                        res_open_next = 1'b1;
                        res_full_next = 1'b0;
                        d_next        = d_reg + TAB_W'(1);
                        draw_next     = draw_inc;
                    end
                    state_next = S_EMIT;
                end
                else
                begin
                    walk_cmd.start = 1'b1;
                    state_next     = S_WALK;
                end
            end
            S_WALK:
            begin
                if (walk_rsp.done)
                begin
                    res_idx_next  = walk_rsp.chosen;
                    res_open_next = 1'b0;
                    res_full_next = 1'b0;
                    draw_next     = draw_inc;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_DATA_W'(result);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            alpha_reg     <= DISCOUNT_RESET;
            theta_reg     <= CONCENTRATION_RESET;
            d_reg         <= '0;
            draw_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alpha_reg     <= alpha_next;
            theta_reg     <= theta_next;
            d_reg         <= d_next;
            draw_reg      <= draw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        u_reg        <= u_next;
        s_reg        <= s_next;
        p_lo_reg     <= p_lo_next;
        p_hi_reg     <= p_hi_next;
        t_reg        <= t_next;
        y_reg        <= y_next;
        res_idx_reg  <= res_idx_next;
        res_open_reg <= res_open_next;
        res_full_reg <= res_full_next;
    end

endmodule
